### design/rbh_pkg.sv
// rbh_pkg: shared sizes, opcodes, controller states and the command and
// status structs of the range-bin histogram. No dependencies.
package rbh_pkg;

  localparam int NUM_BINS   = 16;
  localparam int COUNT_BITS = 48;
  localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_ENC,
    ST_RD,
    ST_WB,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic write_bounds;
    logic compare;
    logic encode;
    logic read;
    logic writeback;
    logic clear_counts;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic any_match;
  } ctrl_sts_t;

endpackage

### design/rbh_ctrl.sv
// rbh_ctrl: sequencing state machine of the range-bin histogram.
// Depends on rbh_pkg; drives the datapath through rbh_pkg::ctrl_cmd_t.
module rbh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rbh_pkg::ctrl_sts_t sts_i,
  output rbh_pkg::ctrl_cmd_t cmd_o
);

  rbh_pkg::state_e  state_q, state_d;
  rbh_pkg::opcode_e op_q, op_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             out_free;

  assign in_accept = in_valid_i && (state_q == rbh_pkg::ST_IDLE);
  // Output register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbh_pkg::ST_IDLE;
      op_q        <= rbh_pkg::OP_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      rbh_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_o.capture = 1'b1;
          op_d          = rbh_pkg::opcode_e'(opcode_i);
          unique case (rbh_pkg::opcode_e'(opcode_i))
            rbh_pkg::OP_LOAD:  state_d = rbh_pkg::ST_LOAD;
            rbh_pkg::OP_COUNT: state_d = rbh_pkg::ST_CMP;
            rbh_pkg::OP_READ:  state_d = rbh_pkg::ST_RD;
            rbh_pkg::OP_CLEAR: state_d = rbh_pkg::ST_CLEAR;
            default:           state_d = rbh_pkg::ST_IDLE;
          endcase
        end
      end
      rbh_pkg::ST_LOAD: begin
        cmd_o.write_bounds = 1'b1;
        state_d            = rbh_pkg::ST_DONE;
      end
      rbh_pkg::ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = rbh_pkg::ST_ENC;
      end
      rbh_pkg::ST_ENC: begin
        cmd_o.encode = 1'b1;
        state_d      = sts_i.any_match ? rbh_pkg::ST_RD : rbh_pkg::ST_DONE;
      end
      rbh_pkg::ST_RD: begin
        cmd_o.read = 1'b1;
        state_d    = (op_q == rbh_pkg::OP_COUNT) ? rbh_pkg::ST_WB : rbh_pkg::ST_DONE;
      end
      rbh_pkg::ST_WB: begin
        cmd_o.writeback = 1'b1;
        state_d         = rbh_pkg::ST_DONE;
      end
      rbh_pkg::ST_CLEAR: begin
        cmd_o.clear_counts = 1'b1;
        state_d            = rbh_pkg::ST_DONE;
      end
      rbh_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = rbh_pkg::ST_IDLE;
        end
      end
      default: state_d = rbh_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != rbh_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/rbh_datapath.sv
// rbh_datapath: bin bounds, parallel compare, first-match encoder, count
// memory with valid bits and the output register. Depends on rbh_pkg.
module rbh_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rbh_pkg::ctrl_cmd_t              cmd_i,
  output rbh_pkg::ctrl_sts_t              sts_o,
  input  logic                            cfg_we_i,
  input  logic [4:0]                      cfg_wdata_i,
  input  logic [1:0]                      opcode_i,
  input  logic [3:0]                      bin_select_i,
  input  logic signed [31:0]              lower_value_i,
  input  logic signed [31:0]              upper_value_i,
  input  logic signed [31:0]              sample_i,
  output logic                            matched_o,
  output logic [3:0]                      hit_bin_o,
  output logic [47:0]                     count_value_o
);

  localparam logic [rbh_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [4:0]                      active_q;
  rbh_pkg::opcode_e                op_q;
  logic [3:0]                      sel_q;
  logic signed [31:0]              lo_in_q, hi_in_q, smp_q;
  logic signed [31:0]              bin_lo_q [rbh_pkg::NUM_BINS];
  logic signed [31:0]              bin_hi_q [rbh_pkg::NUM_BINS];
  logic [rbh_pkg::NUM_BINS-1:0]    match_d, match_q;
  logic [rbh_pkg::NUM_BINS-1:0]    first_hot;
  logic [rbh_pkg::IDX_W-1:0]       hit_idx_d, hit_idx_q;
  logic                            matched_q;
  logic [rbh_pkg::COUNT_BITS-1:0]  cnt_mem [rbh_pkg::NUM_BINS];
  logic [rbh_pkg::NUM_BINS-1:0]    cnt_vld_q;
  logic [rbh_pkg::COUNT_BITS-1:0]  rd_raw_q;
  logic                            rd_vld_q;
  logic [rbh_pkg::COUNT_BITS-1:0]  rd_cnt;
  logic [rbh_pkg::COUNT_BITS-1:0]  cnt_next;
  logic [rbh_pkg::IDX_W-1:0]       sel_idx, rd_addr;
  logic                            sel_ok;
  logic                            matched_out_q;
  logic [3:0]                      hit_out_q;
  logic [47:0]                     count_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= rbh_pkg::opcode_e'(opcode_i);
      sel_q   <= bin_select_i;
      lo_in_q <= lower_value_i;
      hi_in_q <= upper_value_i;
      smp_q   <= sample_i;
    end
  end

  assign sel_ok  = (int'(sel_q) < rbh_pkg::NUM_BINS);
  assign sel_idx = rbh_pkg::IDX_W'(sel_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_bounds && sel_ok) begin
      bin_lo_q[sel_idx] <= lo_in_q;
      bin_hi_q[sel_idx] <= hi_in_q;
    end
  end

  always_comb begin
    for (int j = 0; j < rbh_pkg::NUM_BINS; j++) begin
      match_d[j] = (j < int'(active_q)) && (bin_lo_q[j] <= smp_q) && (smp_q <= bin_hi_q[j]);
    end
  end

  // Isolate the lowest set bit, then OR the indexes of the one-hot vector.
  assign first_hot = match_q & (~match_q + 1'b1);

  always_comb begin
    hit_idx_d = '0;
    for (int j = 0; j < rbh_pkg::NUM_BINS; j++) begin
      hit_idx_d = hit_idx_d | (first_hot[j] ? rbh_pkg::IDX_W'(j) : '0);
    end
  end

  assign sts_o.any_match = |match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= '0;
      matched_q <= 1'b0;
      hit_idx_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        matched_q <= 1'b0;
        hit_idx_q <= '0;
      end
      if (cmd_i.compare) begin
        match_q <= match_d;
      end
      if (cmd_i.encode) begin
        matched_q <= |match_q;
        hit_idx_q <= hit_idx_d;
      end
    end
  end

  assign rd_addr = (op_q == rbh_pkg::OP_COUNT) ? hit_idx_q : sel_idx;
  assign rd_cnt  = rd_vld_q ? rd_raw_q : '0;
  assign cnt_next = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.writeback) begin
      cnt_mem[hit_idx_q] <= cnt_next;
    end
    if (cmd_i.read) begin
      rd_raw_q <= cnt_mem[rd_addr];
      rd_vld_q <= cnt_vld_q[rd_addr];
    end
  end

  // Valid bits stand in for clearing the count memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.clear_counts) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.writeback) begin
      cnt_vld_q[hit_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      matched_out_q <= (op_q == rbh_pkg::OP_COUNT) && matched_q;
      hit_out_q     <= (op_q == rbh_pkg::OP_COUNT) ? 4'(hit_idx_q) : 4'd0;
      count_out_q   <= ((op_q == rbh_pkg::OP_READ) && sel_ok) ? 48'(rd_cnt) : 48'd0;
    end
  end

  assign matched_o     = matched_out_q;
  assign hit_bin_o     = hit_out_q;
  assign count_value_o = count_out_q;

endmodule

### design/range_bin_histogram.sv
// range_bin_histogram: top level, joins rbh_ctrl and rbh_datapath.
// Depends on rbh_pkg, rbh_ctrl and rbh_datapath.
//
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_stall_o   opcode, bin_select, lower/upper_value, sample
// result    out        out_valid_o / out_stall_i matched, hit_bin, count_value
// config    in         cfg_we_i                  cfg_wdata_i (active_bins)
//
// One request at a time, one result per request. Load, clear and read pass
// through their own state (write bounds, clear counts, count memory read); count
// passes compare and first-match encode, then on a match count memory read and
// write back, the longest path given the single read port and read-modify-write.
// All end in the done state, which loads the result register once it is free.
// Reset clears state, config and count valid bits at once; bounds hold undefined
// values until loaded. A stalled result holds in the output register while the
// block takes the next request, which then waits for it.
module range_bin_histogram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         bin_select_i,
  input  logic signed [31:0] lower_value_i,
  input  logic signed [31:0] upper_value_i,
  input  logic signed [31:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               matched_o,
  output logic [3:0]         hit_bin_o,
  output logic [47:0]        count_value_o
);

  rbh_pkg::ctrl_cmd_t cmd;
  rbh_pkg::ctrl_sts_t sts;

  // Sequence each request: load, clear, read, or compare, encode, read and write back.
  rbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold bounds and counts; compare all active bins in parallel.
  rbh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .bin_select_i  (bin_select_i),
    .lower_value_i (lower_value_i),
    .upper_value_i (upper_value_i),
    .sample_i      (sample_i),
    .matched_o     (matched_o),
    .hit_bin_o     (hit_bin_o),
    .count_value_o (count_value_o)
  );

`ifndef SYNTH
  // Go busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy");

  // A result with no match carries a zero bin index.
  a_hit_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (hit_bin_o == 4'd0))
    else $error("hit_bin set without a match");

  // A count result and a read result never mix.
  a_match_or_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && matched_o) |-> (count_value_o == 48'd0))
    else $error("matched and count_value both set");
`endif

endmodule

### bench/range_bin_histogram_checker.sv
`timescale 1ns / 1ps
// range_bin_histogram_checker: watches the request, result and config ports,
// predicts every result of the range-bin histogram and compares it field by field.
// Depends on rbh_pkg.
module range_bin_histogram_checker
  import rbh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         bin_select_i,
  input  logic signed [31:0] lower_value_i,
  input  logic signed [31:0] upper_value_i,
  input  logic signed [31:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               matched_i,
  input  logic [3:0]         hit_bin_i,
  input  logic [47:0]        count_value_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 binned_o,
  output int                 dropped_o
);

  typedef struct packed {
    logic        matched;
    logic [3:0]  hit_bin;
    logic [47:0] count_value;
  } histo_answer_t;

  logic signed [31:0]     bin_low [NUM_BINS];
  logic signed [31:0]     bin_high[NUM_BINS];
  logic [COUNT_BITS-1:0]  bin_tally[NUM_BINS];
  logic [4:0]             bins_in_play;
  histo_answer_t          pending_answers[$];
  int                     errors;
  int                     checked;
  int                     binned;
  int                     dropped;

  // Apply one request to the shadow histogram and return the answer it owes.
  function automatic histo_answer_t apply_request(opcode_e op, logic [3:0] sel,
                                                  logic signed [31:0] lo,
                                                  logic signed [31:0] hi,
                                                  logic signed [31:0] smp);
    histo_answer_t ans;
    int            n;
    ans = '0;
    case (op)
      OP_LOAD: begin
        if (sel < NUM_BINS) begin
          bin_low[sel]  = lo;
          bin_high[sel] = hi;
        end
      end
      OP_COUNT: begin
        n = (bins_in_play > NUM_BINS) ? NUM_BINS : int'(bins_in_play);
        for (int j = 0; j < n; j++) begin
          if (!ans.matched && bin_low[j] <= smp && smp <= bin_high[j]) begin
            ans.matched = 1'b1;
            ans.hit_bin = 4'(j);
            if (bin_tally[j] != '1) bin_tally[j] = bin_tally[j] + 1'b1;
          end
        end
      end
      OP_READ: begin
        if (sel < NUM_BINS) ans.count_value = 48'(bin_tally[sel]);
      end
      default: begin
        foreach (bin_tally[j]) bin_tally[j] = '0;
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk_i) begin
    histo_answer_t got;
    histo_answer_t want;
    if (!rst_ni) begin
      foreach (bin_tally[j]) begin
        bin_tally[j] = '0;
        bin_low[j]   = '0;
        bin_high[j]  = '0;
      end
      bins_in_play = '0;
      pending_answers.delete();
      errors  = 0;
      checked = 0;
      binned  = 0;
      dropped = 0;
    end else begin
      if (cfg_we_i) bins_in_play = cfg_wdata_i;
      // Results first: a request and its own result never share an edge.
      if (out_valid_i && !out_stall_i) begin
        got.matched     = matched_i;
        got.hit_bin     = hit_bin_i;
        got.count_value = count_value_i;
        checked++;
        if (pending_answers.size() == 0) begin
          $error("result with no request outstanding: matched %0d hit_bin %0d count %0d",
                 got.matched, got.hit_bin, got.count_value);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, got.matched);
            errors++;
          end
          if (got.hit_bin !== want.hit_bin) begin
            $error("hit_bin: expected %0d, got %0d", want.hit_bin, got.hit_bin);
            errors++;
          end
          if (got.count_value !== want.count_value) begin
            $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_request(opcode_e'(opcode_i), bin_select_i, lower_value_i,
                             upper_value_i, sample_i);
        if (opcode_e'(opcode_i) == OP_COUNT) begin
          if (want.matched) binned++;
          else dropped++;
        end
        pending_answers.push_back(want);
      end
    end
    // Publish with nonblocking writes so readers at this edge see settled values.
    fail_count_o <= errors;
    pending_o    <= pending_answers.size();
    checked_o    <= checked;
    binned_o     <= binned;
    dropped_o    <= dropped;
  end

endmodule

### bench/range_bin_histogram_test.sv
`timescale 1ns / 1ps
// range_bin_histogram_test: drives requests, result stalls and active-bin settings
// into range_bin_histogram and reports the verdict of range_bin_histogram_checker.
// Depends on rbh_pkg, range_bin_histogram and range_bin_histogram_checker.
module range_bin_histogram_test;
  import rbh_pkg::*;

  localparam int                 ITEMS_PER_PHASE = 155;
  localparam int                 NUM_PHASES      = 9;
  localparam int                 WATCHDOG_LIMIT  = 2000;
  localparam int                 DRAIN_CYCLES    = 12;
  localparam logic signed [31:0] S32_MIN         = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX         = 32'sh7fff_ffff;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [4:0]         cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i      = OP_LOAD;
  logic [3:0]         bin_select_i  = '0;
  logic signed [31:0] lower_value_i = '0;
  logic signed [31:0] upper_value_i = '0;
  logic signed [31:0] sample_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               matched_o;
  logic [3:0]         hit_bin_o;
  logic [47:0]        count_value_o;

  int fail_count;
  int pending;
  int checked;
  int binned;
  int dropped;
  int quiet_cycles = 0;

  // Gaps on the request side and stalls on the result side; both off in quiet phases.
  bit idle_on = 1'b0;

  // Bounds as loaded, kept only to aim samples at and around real bins.
  logic signed [31:0] aim_low [NUM_BINS];
  logic signed [31:0] aim_high[NUM_BINS];

  int active_plan[NUM_PHASES] = '{16, 1, 31, 0, 5, 17, 9, 3, 16};

  range_bin_histogram dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .bin_select_i  (bin_select_i),
    .lower_value_i (lower_value_i),
    .upper_value_i (upper_value_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .matched_o     (matched_o),
    .hit_bin_o     (hit_bin_o),
    .count_value_o (count_value_o)
  );

  range_bin_histogram_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .bin_select_i  (bin_select_i),
    .lower_value_i (lower_value_i),
    .upper_value_i (upper_value_i),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .matched_i     (matched_o),
    .hit_bin_i     (hit_bin_o),
    .count_value_i (count_value_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .binned_o      (binned),
    .dropped_o     (dropped)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in random bursts while idling is on.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Abort when no request and no result has moved for too long.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("range_bin_histogram_test failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it. Valid stays high on
  // return, so back-to-back requests never drop it between items.
  task automatic send_request(opcode_e op, logic [3:0] sel, logic signed [31:0] lo,
                              logic signed [31:0] hi, logic signed [31:0] smp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    bin_select_i  <= sel;
    lower_value_i <= lo;
    upper_value_i <= hi;
    sample_i      <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Fields an opcode ignores carry random bits, so every input bit toggles.
  task automatic load_bin(logic [3:0] sel, logic signed [31:0] lo, logic signed [31:0] hi);
    aim_low[sel]  = lo;
    aim_high[sel] = hi;
    send_request(OP_LOAD, sel, lo, hi, $urandom);
  endtask

  task automatic count_sample(logic signed [31:0] smp);
    send_request(OP_COUNT, 4'($urandom), $urandom, $urandom, smp);
  endtask

  task automatic read_bin(logic [3:0] sel);
    send_request(OP_READ, sel, $urandom, $urandom, $urandom);
  endtask

  task automatic clear_all();
    send_request(OP_CLEAR, 4'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Drop valid and wait until every request has been answered.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Change the number of active bins only with the block idle.
  task automatic write_active(logic [4:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Aim a sample: mostly inside a loaded bin or on its edges, else anywhere.
  function automatic logic signed [31:0] pick_sample();
    int unsigned        j;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    j    = $urandom_range(0, NUM_BINS - 1);
    lo   = aim_low[j];
    hi   = aim_high[j];
    span = longint'(hi) - longint'(lo) + 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return (span > 0) ? lo + 32'(longint'({32'b0, $urandom}) % span) : lo;
      5:             return lo;
      6:             return hi;
      7:             return lo - 1;
      8:             return hi + 1;
      default: begin
        case ($urandom_range(0, 3))
          0:       return S32_MIN;
          1:       return S32_MAX;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mix of loads, counts, reads and rare clears so tallies build up between clears.
  task automatic random_request();
    int                 roll;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] t;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      case ($urandom_range(0, 5))
        0: begin
          // narrow range; wraps to an empty one near the top
          lo = $urandom;
          hi = lo + $urandom_range(0, 1000);
        end
        1: begin
          lo = $urandom;
          hi = $urandom;
          if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
        end
        2: begin
          lo = $urandom;
          hi = $urandom;
        end
        3: begin
          lo = $urandom;
          hi = lo - $urandom_range(1, 50);
        end
        4: begin
          lo = S32_MIN;
          hi = $urandom;
        end
        default: begin
          lo = $urandom;
          hi = S32_MAX;
        end
      endcase
      load_bin(4'($urandom), lo, hi);
    end else if (roll < 72) begin
      count_sample(pick_sample());
    end else if (roll < 97) begin
      read_bin(4'($urandom));
    end else begin
      clear_all();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No bins active: every sample drops; clear on an empty table.
    write_active(5'd0);
    count_sample(S32_MAX);
    clear_all();

    // Load every bin before any of them takes part in matching: single points at
    // both extremes, overlapping ranges, an empty range and the full range.
    load_bin(4'd0, S32_MIN, S32_MIN);
    load_bin(4'd1, S32_MAX, S32_MAX);
    load_bin(4'd2, -32'sd100, 32'sd100);
    load_bin(4'd3, 32'sd0, 32'sd0);
    load_bin(4'd4, 32'sd200, -32'sd200);
    load_bin(4'd5, S32_MIN, S32_MAX);
    for (int j = 6; j < NUM_BINS; j++) load_bin(4'(j), 32'(1000 * j), 32'(1000 * j + 99));

    // All bins active: first match wins over overlaps, the empty bin is skipped.
    write_active(5'd16);
    count_sample(S32_MIN);
    count_sample(S32_MAX);
    count_sample(32'sd0);
    count_sample(-32'sd150);
    load_bin(4'd5, -32'sd300, -32'sd120);
    count_sample(32'sd15050);
    read_bin(4'd0);
    read_bin(4'd5);
    clear_all();
    read_bin(4'd5);

    // Random phases over several settings, above the bin count too; the
    // next-to-last phase picks its setting at random. Idling is off every third
    // phase and in the final one.
    active_plan[7] = $urandom_range(2, 15);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(5'(active_plan[p]));
      idle_on = (p % 3 != 2) && (p != NUM_PHASES - 1);
      repeat (ITEMS_PER_PHASE) random_request();
    end

    drain();
    idle_on = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests across %0d active-bin settings (0 through 31)",
             checked, NUM_PHASES + 2);
    $display("samples binned: %0d, samples dropped: %0d", binned, dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("range_bin_histogram_test passed");
    end else begin
      $display("range_bin_histogram_test failed");
    end
    $finish;
  end

endmodule

### sim.f
design/rbh_pkg.sv
design/rbh_ctrl.sv
design/rbh_datapath.sv
design/range_bin_histogram.sv
bench/range_bin_histogram_checker.sv
bench/range_bin_histogram_test.sv
